// ===== src/ids_pkg.sv =====
`timescale 1ns / 1ps

package ids_pkg;

  // Field widths of the channels.
  localparam int unsigned CrystalW  = 26;
  localparam int unsigned TargetW   = 32;
  localparam int unsigned SelW      = 2;
  localparam int unsigned MultW     = 6;
  localparam int unsigned DivW      = 8;
  localparam int unsigned FreqW     = 28;
  localparam int unsigned ErrW      = 32;
  localparam int unsigned PllP1W    = 13;
  localparam int unsigned DivP1W    = 15;
  localparam int unsigned BaseAddrW = 6;
  localparam int unsigned CtrlAddrW = 5;
  localparam int unsigned PhaseAddrW = 8;

  // Internal widths.
  localparam int unsigned VcoW      = 32;
  localparam int unsigned NumW      = 30;
  localparam int unsigned StepBits  = 3;
  localparam int unsigned DivCycles = NumW / StepBits;
  localparam int unsigned CntW      = $clog2(DivCycles);

  localparam logic [CrystalW-1:0] CRYSTAL_RESET = CrystalW'(25000000);
  localparam logic [VcoW-1:0]     VCO_LOW       = VcoW'(600000000);
  localparam logic [VcoW-1:0]     VCO_HIGH      = VcoW'(900000000);
  localparam logic [MultW-1:0]    MULT_FIRST    = MultW'(25);
  localparam logic [MultW-1:0]    MULT_LAST     = MultW'(36);
  localparam logic [DivW-1:0]     DIV_FIRST     = DivW'(6);
  localparam logic [DivW-1:0]     DIV_LAST      = DivW'(254);
  localparam logic [PllP1W-1:0]   PLL_P1_OFFSET = PllP1W'(512);
  localparam logic [DivP1W-1:0]   DIV_P1_OFFSET = DivP1W'(512);
  localparam logic [BaseAddrW-1:0]  MS_BASE     = BaseAddrW'(42);
  localparam logic [CtrlAddrW-1:0]  CTRL_BASE   = CtrlAddrW'(16);
  localparam logic [PhaseAddrW-1:0] PHASE_BASE  = PhaseAddrW'(165);
  localparam logic [SelW-1:0]       SEL_LAST    = SelW'(2);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_VCO    = 5'b00010,
    S_DIV    = 5'b00100,
    S_EVAL   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

endpackage

// ===== src/ids_intf.sv =====
`timescale 1ns / 1ps

interface ids_req_if;
  logic                         valid;
  logic                         ready;
  logic [ids_pkg::TargetW-1:0]  target_hz;
  logic [ids_pkg::SelW-1:0]     output_select;

  modport source (output valid, target_hz, output_select, input ready);
  modport sink   (input valid, target_hz, output_select, output ready);
endinterface

interface ids_res_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [ids_pkg::MultW-1:0]      pll_multiplier;
  logic [ids_pkg::DivW-1:0]       output_divider;
  logic [ids_pkg::FreqW-1:0]      achieved_hz;
  logic [ids_pkg::ErrW-1:0]       error_hz;
  logic [ids_pkg::PllP1W-1:0]     pll_p1;
  logic [ids_pkg::DivP1W-1:0]     divider_p1;
  logic [ids_pkg::BaseAddrW-1:0]  divider_base_address;
  logic [ids_pkg::CtrlAddrW-1:0]  control_address;
  logic [ids_pkg::PhaseAddrW-1:0] phase_address;

  modport source (output valid, found, pll_multiplier, output_divider, achieved_hz,
                  error_hz, pll_p1, divider_p1, divider_base_address,
                  control_address, phase_address,
                  input ready);
  modport sink   (input valid, found, pll_multiplier, output_divider, achieved_hz,
                  error_hz, pll_p1, divider_p1, divider_base_address,
                  control_address, phase_address,
                  output ready);
endinterface

interface ids_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ids_pkg::CrystalW-1:0]  crystal_hz;

  modport source (output valid, crystal_hz, input ready);
  modport sink   (input valid, crystal_hz, output ready);
endinterface

// ===== src/integer_clock_divider_search.sv =====
`timescale 1ns / 1ps

// Integer clock divider search.
// req_i takes a target frequency and an output number; res_o returns one item
// per request with the chosen PLL multiplier, even output divider, achieved
// frequency, error, P1 words and register addresses. cfg_i writes the crystal
// frequency and is always ready; write it only while no request is in flight.
// A request is taken only while the search engine is idle. Each multiplier
// first gets its VCO range test; each candidate divider of a VCO in range
// then goes through the shared restoring divider, which retires 3 quotient
// bits per cycle, and an error compare. A full search covers 12 multipliers;
// a rejected request (zero target, output three) or a crystal with no VCO in
// range returns without any division. The result sits in an output register,
// so the next request is taken while a stalled result waits; the engine only
// stalls at the end of its search if that register is still full.
// Reset clears the state machine and the output valid and sets the crystal
// frequency to 25 MHz.
module integer_clock_divider_search (
  input  logic      clk_i,
  input  logic      rst_ni,
  ids_cfg_if.sink   cfg_i,
  ids_req_if.sink   req_i,
  ids_res_if.source res_o
);

  ids_pkg::state_e                   state_q, state_d;
  logic [ids_pkg::CrystalW-1:0]      crystal_q;
  logic [ids_pkg::TargetW-1:0]       target_q, target_d;
  logic [ids_pkg::SelW-1:0]          sel_q, sel_d;
  logic [ids_pkg::VcoW-1:0]          vco_q, vco_d;
  logic [ids_pkg::MultW-1:0]         mult_q, mult_d;
  logic [ids_pkg::DivW-1:0]          div_q, div_d;
  logic [ids_pkg::NumW-1:0]          num_q, num_d;
  logic [ids_pkg::DivW-1:0]          rem_q, rem_d;
  logic [ids_pkg::NumW-1:0]          quo_q, quo_d;
  logic [ids_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic                              have_q, have_d;
  logic [ids_pkg::MultW-1:0]         best_mult_q, best_mult_d;
  logic [ids_pkg::DivW-1:0]          best_div_q, best_div_d;
  logic [ids_pkg::FreqW-1:0]         best_f_q, best_f_d;
  logic [ids_pkg::ErrW-1:0]          best_err_q, best_err_d;

  logic                              res_valid_q;
  logic                              load_res;

  logic [ids_pkg::DivW:0]            step_rem [ids_pkg::StepBits+1];
  logic [ids_pkg::StepBits-1:0]      step_q;
  logic [ids_pkg::ErrW-1:0]          cand_f;
  logic [ids_pkg::ErrW-1:0]          cand_err;
  logic                              vco_in_range;
  logic [ids_pkg::DivW-1:0]          div_next;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ids_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_q <= ids_pkg::CRYSTAL_RESET;
    end else if (cfg_i.valid) begin
      crystal_q <= cfg_i.crystal_hz;
    end
  end

  // Three restoring steps of the shared divider per cycle.
  always_comb begin
    step_rem[0] = {1'b0, rem_q};
    step_q      = '0;
    for (int k = 0; k < ids_pkg::StepBits; k++) begin
      step_rem[k+1] = {step_rem[k][ids_pkg::DivW-1:0], num_q[ids_pkg::NumW-1-k]};
      if (step_rem[k+1] >= {1'b0, div_q}) begin
        step_rem[k+1] = step_rem[k+1] - {1'b0, div_q};
        step_q[ids_pkg::StepBits-1-k] = 1'b1;
      end
    end
  end

  assign cand_f   = ids_pkg::ErrW'(quo_q[ids_pkg::FreqW-1:0]);
  assign cand_err = (cand_f > target_q) ? (cand_f - target_q) : (target_q - cand_f);
  assign vco_in_range = (vco_q >= ids_pkg::VCO_LOW) && (vco_q <= ids_pkg::VCO_HIGH);
  assign div_next = div_q + ids_pkg::DivW'(2);
  assign load_res = (state_q == ids_pkg::S_FINISH) && (!res_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    sel_d       = sel_q;
    vco_d       = vco_q;
    mult_d      = mult_q;
    div_d       = div_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    have_d      = have_q;
    best_mult_d = best_mult_q;
    best_div_d  = best_div_q;
    best_f_d    = best_f_q;
    best_err_d  = best_err_q;

    unique case (state_q)
      ids_pkg::S_IDLE: begin
        if (req_i.valid) begin
          target_d = req_i.target_hz;
          sel_d    = req_i.output_select;
          have_d   = 1'b0;
          mult_d   = ids_pkg::MULT_FIRST;
          vco_d    = ids_pkg::VcoW'(crystal_q) * ids_pkg::VcoW'(ids_pkg::MULT_FIRST);
          if (req_i.target_hz == '0 || req_i.output_select > ids_pkg::SEL_LAST) begin
            state_d = ids_pkg::S_FINISH;
          end else begin
            state_d = ids_pkg::S_VCO;
          end
        end
      end
      ids_pkg::S_VCO: begin
        if (vco_in_range) begin
          div_d   = ids_pkg::DIV_FIRST;
          num_d   = vco_q[ids_pkg::NumW-1:0] + ids_pkg::NumW'(ids_pkg::DIV_FIRST >> 1);
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ids_pkg::S_DIV;
        end else if (mult_q == ids_pkg::MULT_LAST) begin
          state_d = ids_pkg::S_FINISH;
        end else begin
          mult_d = mult_q + ids_pkg::MultW'(1);
          vco_d  = vco_q + ids_pkg::VcoW'(crystal_q);
        end
      end
      ids_pkg::S_DIV: begin
        num_d = num_q << ids_pkg::StepBits;
        rem_d = step_rem[ids_pkg::StepBits][ids_pkg::DivW-1:0];
        quo_d = {quo_q[ids_pkg::NumW-ids_pkg::StepBits-1:0], step_q};
        cnt_d = cnt_q + ids_pkg::CntW'(1);
        if (cnt_q == ids_pkg::CntW'(ids_pkg::DivCycles - 1)) begin
          state_d = ids_pkg::S_EVAL;
        end
      end
      ids_pkg::S_EVAL: begin
        // Strictly smaller error wins, so ties keep the earlier candidate.
        if (!have_q || cand_err < best_err_q) begin
          have_d      = 1'b1;
          best_err_d  = cand_err;
          best_mult_d = mult_q;
          best_div_d  = div_q;
          best_f_d    = quo_q[ids_pkg::FreqW-1:0];
        end
        if (div_q != ids_pkg::DIV_LAST) begin
          div_d   = div_next;
          num_d   = vco_q[ids_pkg::NumW-1:0] + ids_pkg::NumW'(div_next >> 1);
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ids_pkg::S_DIV;
        end else if (mult_q == ids_pkg::MULT_LAST) begin
          state_d = ids_pkg::S_FINISH;
        end else begin
          mult_d  = mult_q + ids_pkg::MultW'(1);
          vco_d   = vco_q + ids_pkg::VcoW'(crystal_q);
          state_d = ids_pkg::S_VCO;
        end
      end
      ids_pkg::S_FINISH: begin
        if (load_res) begin
          state_d = ids_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ids_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ids_pkg::S_IDLE;
      have_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      have_q  <= have_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    sel_q       <= sel_d;
    vco_q       <= vco_d;
    mult_q      <= mult_d;
    div_q       <= div_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    best_mult_q <= best_mult_d;
    best_div_q  <= best_div_d;
    best_f_q    <= best_f_d;
    best_err_q  <= best_err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_o.found <= have_q;
      if (have_q) begin
        res_o.pll_multiplier       <= best_mult_q;
        res_o.output_divider       <= best_div_q;
        res_o.achieved_hz          <= best_f_q;
        res_o.error_hz             <= best_err_q;
        res_o.pll_p1               <= {best_mult_q, 7'b0} - ids_pkg::PLL_P1_OFFSET;
        res_o.divider_p1           <= {best_div_q, 7'b0} - ids_pkg::DIV_P1_OFFSET;
        res_o.divider_base_address <= ids_pkg::MS_BASE + ids_pkg::BaseAddrW'({sel_q, 3'b0});
        res_o.control_address      <= ids_pkg::CTRL_BASE + ids_pkg::CtrlAddrW'(sel_q);
        res_o.phase_address        <= ids_pkg::PHASE_BASE + ids_pkg::PhaseAddrW'(sel_q);
      end else begin
        res_o.pll_multiplier       <= '0;
        res_o.output_divider       <= '0;
        res_o.achieved_hz          <= '0;
        res_o.error_hz             <= '0;
        res_o.pll_p1               <= '0;
        res_o.divider_p1           <= '0;
        res_o.divider_base_address <= '0;
        res_o.control_address      <= '0;
        res_o.phase_address        <= '0;
      end
    end
  end

  assign res_o.valid = res_valid_q;

  // The best error of one search never grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (have_q && $past(have_q)) |-> (best_err_q <= $past(best_err_q)))
    else $error("best error increased during a search");

  // A found result names a multiplier and an even divider from the search space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.found) |->
      (res_o.pll_multiplier >= ids_pkg::MULT_FIRST &&
       res_o.pll_multiplier <= ids_pkg::MULT_LAST &&
       res_o.output_divider >= ids_pkg::DIV_FIRST && !res_o.output_divider[0]))
    else $error("found result outside the search space");

  // A result without a pair carries zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.found) |->
      (res_o.pll_multiplier == '0 && res_o.output_divider == '0 &&
       res_o.achieved_hz == '0 && res_o.error_hz == '0 &&
       res_o.phase_address == '0))
    else $error("result without a pair has nonzero fields");

  // The divider leaves its iteration only after the last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ids_pkg::S_EVAL) |->
      ($past(state_q) == ids_pkg::S_DIV &&
       $past(cnt_q) == ids_pkg::CntW'(ids_pkg::DivCycles - 1)))
    else $error("error compare without a finished division");

  // The divider remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ids_pkg::S_DIV || state_q == ids_pkg::S_EVAL) |-> (rem_q < div_q))
    else $error("divider remainder out of range");

endmodule

// ===== tb/integer_clock_divider_search_tb.sv =====
`timescale 1ns / 1ps

module integer_clock_divider_search_tb;

  localparam int unsigned P1_SCALE     = 128;
  localparam int unsigned MS_STRIDE    = 8;
  localparam int unsigned CYCLE_LIMIT  = 15000000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned SEND_LONGEST = 200;
  localparam int unsigned STALL_LONGEST = 3000;

  typedef struct packed {
    logic                           found;
    logic [ids_pkg::MultW-1:0]      pll_multiplier;
    logic [ids_pkg::DivW-1:0]       output_divider;
    logic [ids_pkg::FreqW-1:0]      achieved_hz;
    logic [ids_pkg::ErrW-1:0]       error_hz;
    logic [ids_pkg::PllP1W-1:0]     pll_p1;
    logic [ids_pkg::DivP1W-1:0]     divider_p1;
    logic [ids_pkg::BaseAddrW-1:0]  divider_base_address;
    logic [ids_pkg::CtrlAddrW-1:0]  control_address;
    logic [ids_pkg::PhaseAddrW-1:0] phase_address;
  } pair_result_t;

  logic clk_i;
  logic rst_ni;

  ids_cfg_if cfg_if ();
  ids_req_if req_if ();
  ids_res_if res_if ();

  integer_clock_divider_search DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  pair_result_t                   predicted_pairs[$];
  pair_result_t                   got_pair;
  pair_result_t                   want_pair;
  logic [ids_pkg::CrystalW-1:0]   crystal_setting = ids_pkg::CRYSTAL_RESET;
  bit                             no_idle = 1'b0;
  int unsigned                    stall_left = 0;
  int unsigned                    cycle_count = 0;
  int unsigned                    mismatch_count = 0;
  int unsigned                    requests_sent = 0;
  int unsigned                    results_seen = 0;
  int unsigned                    found_count = 0;
  int unsigned                    crystal_writes = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_clock_divider_search_tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s got %0d expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Scans multipliers, then even dividers, keeping the first strictly best error.
  function automatic pair_result_t search_best_pair(
      input logic [ids_pkg::TargetW-1:0] target,
      input logic [ids_pkg::SelW-1:0] sel);
    pair_result_t r;
    bit           have;
    logic [63:0]  vco;
    logic [31:0]  f;
    logic [31:0]  err;
    int unsigned  mult;
    int unsigned  div;
    r = '0;
    have = 1'b0;
    if (target == '0 || sel > ids_pkg::SEL_LAST) return r;
    for (mult = ids_pkg::MULT_FIRST; mult <= ids_pkg::MULT_LAST; mult++) begin
      vco = 64'(crystal_setting) * 64'(mult);
      if (vco < 64'(ids_pkg::VCO_LOW) || vco > 64'(ids_pkg::VCO_HIGH)) continue;
      for (div = ids_pkg::DIV_FIRST; div <= ids_pkg::DIV_LAST; div += 2) begin
        f = 32'((vco + 64'(div / 2)) / 64'(div));
        err = (f > target) ? f - target : target - f;
        if (!have || err < r.error_hz) begin
          have = 1'b1;
          r.pll_multiplier = ids_pkg::MultW'(mult);
          r.output_divider = ids_pkg::DivW'(div);
          r.achieved_hz = ids_pkg::FreqW'(f);
          r.error_hz = err;
        end
      end
    end
    if (!have) return r;
    r.found = 1'b1;
    r.pll_p1 = ids_pkg::PllP1W'(P1_SCALE * r.pll_multiplier) - ids_pkg::PLL_P1_OFFSET;
    r.divider_p1 = ids_pkg::DivP1W'(P1_SCALE * r.output_divider) - ids_pkg::DIV_P1_OFFSET;
    r.divider_base_address = ids_pkg::MS_BASE + ids_pkg::BaseAddrW'(MS_STRIDE * sel);
    r.control_address = ids_pkg::CTRL_BASE + ids_pkg::CtrlAddrW'(sel);
    r.phase_address = ids_pkg::PHASE_BASE + ids_pkg::PhaseAddrW'(sel);
    return r;
  endfunction

  function automatic int unsigned idle_length(input int unsigned longest);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(13, longest);
  endfunction

  function automatic logic [ids_pkg::TargetW-1:0] random_target();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick < 4) return $urandom();
    if (pick < 6) return $urandom_range(1, 4000000);
    return $urandom_range(2000000, 160000000);
  endfunction

  function automatic logic [ids_pkg::SelW-1:0] random_select();
    if ($urandom_range(0, 7) == 0) return ids_pkg::SelW'(3);
    return ids_pkg::SelW'($urandom_range(0, ids_pkg::SEL_LAST));
  endfunction

  // Called at a clock edge; returns at the edge where the item is accepted.
  task automatic send_request(input logic [ids_pkg::TargetW-1:0] target,
                              input logic [ids_pkg::SelW-1:0] sel);
    int unsigned gap;
    gap = idle_length(SEND_LONGEST);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predicted_pairs.push_back(search_best_pair(target, sel));
    req_if.valid <= 1'b1;
    req_if.target_hz <= target;
    req_if.output_select <= sel;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // The crystal may only change once every outstanding search has returned.
  task automatic write_crystal(input logic [ids_pkg::CrystalW-1:0] hz);
    req_if.valid <= 1'b0;
    while (predicted_pairs.size() != 0) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.crystal_hz <= hz;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    crystal_setting = hz;
    crystal_writes++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_pair.found = res_if.found;
        got_pair.pll_multiplier = res_if.pll_multiplier;
        got_pair.output_divider = res_if.output_divider;
        got_pair.achieved_hz = res_if.achieved_hz;
        got_pair.error_hz = res_if.error_hz;
        got_pair.pll_p1 = res_if.pll_p1;
        got_pair.divider_p1 = res_if.divider_p1;
        got_pair.divider_base_address = res_if.divider_base_address;
        got_pair.control_address = res_if.control_address;
        got_pair.phase_address = res_if.phase_address;
        if (predicted_pairs.size() == 0) begin
          report_mismatch("result item arrived with no request outstanding");
        end else begin
          want_pair = predicted_pairs.pop_front();
          check_field("found", got_pair.found, want_pair.found);
          check_field("pll_multiplier", got_pair.pll_multiplier, want_pair.pll_multiplier);
          check_field("output_divider", got_pair.output_divider, want_pair.output_divider);
          check_field("achieved_hz", got_pair.achieved_hz, want_pair.achieved_hz);
          check_field("error_hz", got_pair.error_hz, want_pair.error_hz);
          check_field("pll_p1", got_pair.pll_p1, want_pair.pll_p1);
          check_field("divider_p1", got_pair.divider_p1, want_pair.divider_p1);
          check_field("divider_base_address", got_pair.divider_base_address,
                      want_pair.divider_base_address);
          check_field("control_address", got_pair.control_address,
                      want_pair.control_address);
          check_field("phase_address", got_pair.phase_address, want_pair.phase_address);
          if (want_pair.found) found_count++;
          results_seen++;
        end
        stall_left = idle_length(STALL_LONGEST);
      end else if (stall_left == 0 && !res_if.valid && !no_idle &&
                   $urandom_range(0, 63) == 0) begin
        // A short hold-off that may catch the next item as it appears.
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_crystal();
    send_request('0, ids_pkg::SelW'(0));
    send_request(32'd10000000, ids_pkg::SelW'(3));
    send_request(32'd1, ids_pkg::SelW'(0));
    send_request(32'hFFFFFFFF, ids_pkg::SelW'(1));
    send_request(32'd150000000, ids_pkg::SelW'(2));
    send_request(32'd3543307, ids_pkg::SelW'(1));
    // Three pairs reach this exactly; the one scanned first must win.
    send_request(32'd62500000, ids_pkg::SelW'(0));
    send_request(32'd27000000, ids_pkg::SelW'(0));
    send_request(32'd100000000, ids_pkg::SelW'(2));
  endtask

  task automatic test_crystal_extremes();
    write_crystal(ids_pkg::CrystalW'(10000000));
    send_request(32'd7000000, ids_pkg::SelW'(0));
    write_crystal(ids_pkg::CrystalW'(40000000));
    send_request(32'd7000000, ids_pkg::SelW'(1));
    write_crystal('0);
    send_request(32'd1000000, ids_pkg::SelW'(2));
    write_crystal('1);
    send_request(32'd50000000, ids_pkg::SelW'(0));
    // Multiplier 25 lands exactly on the lower VCO bound.
    write_crystal(ids_pkg::CrystalW'(24000000));
    send_request(32'd100000000, ids_pkg::SelW'(1));
    send_request(32'd2362205, ids_pkg::SelW'(2));
    write_crystal(ids_pkg::CrystalW'(23999999));
    send_request(32'd24000000, ids_pkg::SelW'(1));
    // Multiplier 25 lands exactly on the upper VCO bound and is the only one.
    write_crystal(ids_pkg::CrystalW'(36000000));
    send_request(32'd150000000, ids_pkg::SelW'(0));
    send_request(32'd3543307, ids_pkg::SelW'(2));
    write_crystal(ids_pkg::CrystalW'(36000001));
    send_request(32'd40000000, ids_pkg::SelW'(0));
  endtask

  task automatic test_random_single_vco();
    write_crystal(ids_pkg::CrystalW'(35000000));
    no_idle = 1'b1;
    repeat (15) send_request(random_target(), random_select());
    no_idle = 1'b0;
    repeat (45) send_request(random_target(), random_select());
  endtask

  task automatic test_random_edge_vco();
    write_crystal(ids_pkg::CrystalW'(36000000));
    repeat (25) send_request(random_target(), random_select());
  endtask

  task automatic test_random_six_vco();
    write_crystal(ids_pkg::CrystalW'(30000000));
    repeat (15) send_request(random_target(), random_select());
  endtask

  task automatic test_random_crystals();
    repeat (4) begin
      write_crystal(ids_pkg::CrystalW'($urandom_range(10000000, 40000000)));
      repeat (4) send_request(random_target(), random_select());
    end
    write_crystal(ids_pkg::CrystalW'($urandom()));
    repeat (4) send_request(random_target(), random_select());
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.crystal_hz <= '0;
    req_if.valid <= 1'b0;
    req_if.target_hz <= '0;
    req_if.output_select <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_crystal();
    test_crystal_extremes();
    test_random_single_vco();
    test_random_edge_vco();
    test_random_six_vco();
    test_random_crystals();

    req_if.valid <= 1'b0;
    while (predicted_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Searched %0d requests under %0d crystal writes plus the reset crystal.",
             requests_sent, crystal_writes);
    $display("%0d results compared, %0d with a pair found, %0d mismatches.",
             results_seen, found_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("integer_clock_divider_search_tb passed");
    end else begin
      $display("integer_clock_divider_search_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ids_pkg.sv
src/ids_intf.sv
src/integer_clock_divider_search.sv
tb/integer_clock_divider_search_tb.sv
